>>> hw/rtl/fpsa_pkg.sv
// Shared types and codes for the fit-policy segment allocator.
package fpsa_pkg;

    typedef enum logic [1:0] {
        OP_INIT     = 2'd0,
        OP_ALLOC    = 2'd1,
        OP_FREE     = 2'd2,
        OP_RESERVED = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        POL_FIRST    = 2'd0,
        POL_BEST     = 2'd1,
        POL_WORST    = 2'd2,
        POL_RESERVED = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD       = 3'd1,
        ST_INIT      = 3'd2,
        ST_NOFIT     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    localparam logic CFG_FIT_POLICY   = 1'b0;
    localparam logic CFG_REGION_BYTES = 1'b1;

    localparam int REG_REGION_RESET = 4096;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] request_size;
        logic [15:0] block_address;
        logic [15:0] block_length;
    } fpsa_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_address;
        logic [15:0] granted_length;
    } fpsa_rsp_t;

    // One free segment: header start and payload length.
    typedef struct packed {
        logic [16:0] start;
        logic [15:0] len;
    } seg_entry_t;

endpackage

>>> hw/rtl/fpsa_seg_mem.sv
// Segment table memory: one write port, one registered read port.
module fpsa_seg_mem
    import fpsa_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output seg_entry_t               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  seg_entry_t               wr_data
);

    seg_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/fit_policy_segment_allocator.sv
// Top level of the fit-policy segment allocator: sequencer over the segment table.
//
//  Channel  | Signals                       | Direction | Transfer when
//  ---------+-------------------------------+-----------+----------------------
//  request  | in_valid, in_stall, in_data   | in        | in_valid & !in_stall
//  response | out_valid, out_stall, out_data| out       | out_valid & !out_stall
//  config   | cfg_we, cfg_index, cfg_data   | in        | cfg_we
//
// One request at a time. in_stall is high from the transfer until the response
// is loaded into the output register. A table scan reads each entry from memory
// and then compares it, and each entry moved in an insert or removal takes a
// further read and write on the table's separate read and write ports.
// Reset closes the region and empties the table; table contents need no clear.
// A held response stalls the sequencer in its last state until it is taken.
module fit_policy_segment_allocator
    import fpsa_pkg::*;
#(
    parameter int MAX_SEGMENTS     = 16,
    parameter int REGION_MAX_BYTES = 65536,
    parameter int PAGE_BYTES       = 4096,
    parameter int HEADER_BYTES     = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  fpsa_req_t   in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output fpsa_rsp_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int RB    = $clog2(REGION_MAX_BYTES + PAGE_BYTES) + 1;
    localparam int AW    = (RB > 19) ? RB : 19;
    localparam logic [AW-1:0] HDR     = AW'(HEADER_BYTES);
    localparam logic [AW-1:0] RMAX    = AW'(REGION_MAX_BYTES);
    localparam logic [AW-1:0] PAGE    = AW'(PAGE_BYTES);
    localparam logic [AW-1:0] MAX16   = AW'(65535);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_INIT_WR,
        S_A_RD, S_A_CHK, S_A_END,
        S_F_RD, S_F_CHK, S_F_MN, S_F_MP, S_F_ACT,
        S_DROP_RD, S_DROP_WR, S_UP_RD, S_UP_WR, S_RESP
    } state_t;

    function automatic logic [15:0] sat16(input logic [AW-1:0] v);
        return (v > MAX16) ? 16'hFFFF : v[15:0];
    endfunction

    state_t            state_reg;
    fpsa_req_t         req_reg;
    fpsa_rsp_t         rsp_reg;
    fpsa_rsp_t         out_reg;
    logic              out_valid_reg;
    logic [1:0]        policy_reg;
    logic [16:0]       region_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic              open_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  pick_idx_reg;
    seg_entry_t        pick_reg;
    seg_entry_t        prev_reg;
    seg_entry_t        next_reg;
    logic              has_next_reg;
    logic              mn_reg;
    logic              mp_reg;
    logic [16:0]       size_reg;
    logic [15:0]       hdr_reg;
    logic [AW-1:0]     acc_reg;

    // Table port controls.
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    seg_entry_t        mem_rd_data;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    seg_entry_t        mem_wr_data;

    // Decode-time arithmetic.
    logic [AW-1:0]     rounded;
    logic [AW-1:0]     free_end;
    logic [16:0]       size_rnd;

    // Allocate compare.
    logic              a_fit;
    logic              a_take;
    logic              a_stop;
    logic [16:0]       a_rem;
    logic              a_split;

    assign rounded  = ((AW'(region_reg) + PAGE - AW'(1)) / PAGE) * PAGE;
    assign free_end = AW'(req_reg.block_address) + AW'(req_reg.block_length);
    assign size_rnd = (17'(req_reg.request_size) + 17'd3) & ~17'd3;

    always_comb
    begin
        a_fit  = 17'(mem_rd_data.len) >= size_reg;
        a_take = 1'b0;
        a_stop = 1'b0;
        case (policy_reg)
            POL_FIRST:
            begin
                a_take = a_fit;
                a_stop = a_fit;
            end
            POL_BEST:
            begin
                a_stop = a_fit && (17'(mem_rd_data.len) == size_reg);
                a_take = a_fit && (a_stop || !found_reg || mem_rd_data.len < pick_reg.len);
            end
            default:
            begin
                a_take = a_fit && (!found_reg || mem_rd_data.len > pick_reg.len);
            end
        endcase
    end

    assign a_rem   = 17'(pick_reg.len) - size_reg;
    assign a_split = AW'(a_rem) >= HDR + AW'(4);

    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg[IDX_W-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg[IDX_W-1:0];
        mem_wr_data = mem_rd_data;
        unique case (state_reg)
            S_INIT_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = '0;
                mem_wr_data = '{start: '0, len: 16'(acc_reg - HDR)};
            end
            S_A_RD, S_F_RD:
            begin
                mem_rd_en = 1'b1;
            end
            S_A_END:
            begin
                mem_wr_en   = found_reg && a_split;
                mem_wr_addr = pick_idx_reg;
                mem_wr_data = '{start: 17'(AW'(pick_reg.start) + HDR + AW'(size_reg)),
                                len: 16'(AW'(a_rem) - HDR)};
            end
            S_F_ACT:
            begin
                if (mp_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = IDX_W'(idx_reg - CNT_W'(1));
                    mem_wr_data = '{start: prev_reg.start,
                                    len: mn_reg ? sat16(acc_reg + HDR + HDR + AW'(next_reg.len))
                                                : sat16(acc_reg + HDR)};
                end
                else if (mn_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = '{start: 17'(hdr_reg),
                                    len: sat16(AW'(req_reg.block_length) + HDR
                                               + AW'(next_reg.len))};
                end
            end
            S_DROP_RD:
            begin
                mem_rd_en   = (idx_reg + CNT_W'(1)) < count_reg;
                mem_rd_addr = IDX_W'(idx_reg + CNT_W'(1));
            end
            S_DROP_WR:
            begin
                mem_wr_en = 1'b1;
            end
            S_UP_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = '{start: 17'(hdr_reg), len: req_reg.block_length};
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IDX_W'(idx_reg - CNT_W'(1));
                end
            end
            S_UP_WR:
            begin
                mem_wr_en = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    fpsa_seg_mem #(
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            region_reg <= 17'(REG_REGION_RESET);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FIT_POLICY)
            begin
                policy_reg <= cfg_data[1:0];
            end
            else
            begin
                region_reg <= cfg_data;
            end
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            open_reg      <= 1'b0;
            found_reg     <= 1'b0;
            has_next_reg  <= 1'b0;
            mn_reg        <= 1'b0;
            mp_reg        <= 1'b0;
            idx_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            // Load a new response when the output register frees up; drop a taken one.
            if (state_reg == S_RESP && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= in_data;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    rsp_reg.granted_address <= '0;
                    rsp_reg.granted_length  <= '0;
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    case (req_reg.opcode)
                        OP_INIT:
                        begin
                            acc_reg <= rounded;
                            if (open_reg)
                            begin
                                rsp_reg.status <= ST_INIT;
                                state_reg      <= S_RESP;
                            end
                            else if (region_reg == '0 || rounded > RMAX || rounded < HDR
                                     || rounded - HDR > MAX16)
                            begin
                                rsp_reg.status <= ST_BAD;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                rsp_reg.status <= ST_OK;
                                state_reg      <= S_INIT_WR;
                            end
                        end
                        OP_ALLOC:
                        begin
                            size_reg <= size_rnd;
                            if (!open_reg)
                            begin
                                rsp_reg.status <= ST_INIT;
                                state_reg      <= S_RESP;
                            end
                            else if (req_reg.request_size == '0 || policy_reg == POL_RESERVED)
                            begin
                                rsp_reg.status <= ST_BAD;
                                state_reg      <= S_RESP;
                            end
                            else if (count_reg == '0)
                            begin
                                rsp_reg.status <= ST_NOFIT;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                rsp_reg.status <= ST_OK;
                                state_reg      <= S_A_RD;
                            end
                        end
                        OP_FREE:
                        begin
                            hdr_reg <= 16'(AW'(req_reg.block_address) - HDR);
                            has_next_reg <= 1'b0;
                            if (!open_reg)
                            begin
                                rsp_reg.status <= ST_INIT;
                                state_reg      <= S_RESP;
                            end
                            else if (AW'(req_reg.block_address) < HDR || free_end > RMAX)
                            begin
                                rsp_reg.status <= ST_BAD;
                                state_reg      <= S_RESP;
                            end
                            else if (count_reg == '0)
                            begin
                                rsp_reg.status <= ST_OK;
                                state_reg      <= S_F_MN;
                            end
                            else
                            begin
                                rsp_reg.status <= ST_OK;
                                state_reg      <= S_F_RD;
                            end
                        end
                        default:
                        begin
                            rsp_reg.status <= ST_BAD;
                            state_reg      <= S_RESP;
                        end
                    endcase
                end
                S_INIT_WR:
                begin
                    count_reg <= CNT_W'(1);
                    open_reg  <= 1'b1;
                    state_reg <= S_RESP;
                end
                S_A_RD:
                begin
                    state_reg <= S_A_CHK;
                end
                S_A_CHK:
                begin
                    if (a_take)
                    begin
                        pick_reg     <= mem_rd_data;
                        pick_idx_reg <= idx_reg[IDX_W-1:0];
                        found_reg    <= 1'b1;
                    end
                    if (a_stop || idx_reg + CNT_W'(1) == count_reg)
                    begin
                        state_reg <= S_A_END;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_A_RD;
                    end
                end
                S_A_END:
                begin
                    if (!found_reg)
                    begin
                        rsp_reg.status <= ST_NOFIT;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        rsp_reg.granted_address <= 16'(AW'(pick_reg.start) + HDR);
                        if (a_split)
                        begin
                            rsp_reg.granted_length <= size_reg[15:0];
                            state_reg              <= S_RESP;
                        end
                        else
                        begin
                            // Grant the whole segment and close the gap it leaves.
                            rsp_reg.granted_length <= pick_reg.len;
                            idx_reg                <= CNT_W'(pick_idx_reg);
                            state_reg              <= S_DROP_RD;
                        end
                    end
                end
                S_F_RD:
                begin
                    state_reg <= S_F_CHK;
                end
                S_F_CHK:
                begin
                    if (AW'(mem_rd_data.start) <= AW'(hdr_reg))
                    begin
                        prev_reg <= mem_rd_data;
                        idx_reg  <= idx_reg + CNT_W'(1);
                        state_reg <= (idx_reg + CNT_W'(1) == count_reg) ? S_F_MN : S_F_RD;
                    end
                    else
                    begin
                        next_reg     <= mem_rd_data;
                        has_next_reg <= 1'b1;
                        state_reg    <= S_F_MN;
                    end
                end
                S_F_MN:
                begin
                    mn_reg <= has_next_reg && (AW'(hdr_reg) + HDR + AW'(req_reg.block_length)
                                               == AW'(next_reg.start));
                    acc_reg   <= AW'(prev_reg.len) + AW'(req_reg.block_length);
                    state_reg <= S_F_MP;
                end
                S_F_MP:
                begin
                    mp_reg <= (idx_reg != '0) && (AW'(prev_reg.start) + HDR + AW'(prev_reg.len)
                                                  == AW'(hdr_reg));
                    state_reg <= S_F_ACT;
                end
                S_F_ACT:
                begin
                    if (mp_reg && mn_reg)
                    begin
                        state_reg <= S_DROP_RD;
                    end
                    else if (mp_reg || mn_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                    else if (count_reg >= CNT_W'(MAX_SEGMENTS))
                    begin
                        rsp_reg.status <= ST_FULL;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        pos_reg   <= idx_reg;
                        idx_reg   <= count_reg;
                        state_reg <= S_UP_RD;
                    end
                end
                S_DROP_RD:
                begin
                    if (idx_reg + CNT_W'(1) < count_reg)
                    begin
                        state_reg <= S_DROP_WR;
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_RESP;
                    end
                end
                S_DROP_WR:
                begin
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_DROP_RD;
                end
                S_UP_RD:
                begin
                    if (idx_reg == pos_reg)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_UP_WR;
                    end
                end
                S_UP_WR:
                begin
                    idx_reg   <= idx_reg - CNT_W'(1);
                    state_reg <= S_UP_RD;
                end
                S_RESP:
                begin
                    // Hold until the output register is free.
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg   <= rsp_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count above table depth");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> count_reg == '0)
        else $error("segments present while region closed");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while not busy afterwards");

    a_open_has_seg: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(open_reg) |-> count_reg == CNT_W'(1))
        else $error("region opened without one segment");
`endif

endmodule
